>>> rtl/bem_pkg.sv
// ============================================================================
// bem_pkg
// Shared types, widths and constants of the band-pass envelope magnitude block.
// ============================================================================
`default_nettype none

package bem_pkg;

    localparam int FREQ_W      = 24;          // frequency and edge width
    localparam int WF_W        = 17;          // width fraction, Q1.16 up to 1.0
    localparam int STEEP_W     = 3;
    localparam int MAX_STEEP   = 7;
    localparam int Q_W         = 17;          // Q16 values up to 1.0
    localparam int POS_W       = 16;          // position quotient bits
    localparam int DIV_W       = FREQ_W + 1;  // numerator, divisor, zone limits
    localparam int N_LANES     = 2;
    localparam int LANE_HP     = 0;           // high-pass term (low edge)
    localparam int LANE_LP     = 1;           // low-pass term (high edge)
    localparam int QS_LAT      = 6;           // stages of one sine unit
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [Q_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [31:0]    SIN_C1   = 32'd1686629713;
    localparam logic [31:0]    SIN_C3   = 32'd693598668;
    localparam logic [31:0]    SIN_C5   = 32'd85569306;
    localparam logic [31:0]    SIN_C7   = 32'd5026995;
    localparam logic [31:0]    SIN_C9   = 32'd172272;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_EDGE   = 2'd0,
        CFG_HIGH_EDGE  = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_STEEPNESS  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TERM_ZERO = 2'd0,
        TERM_ONE  = 2'd1,
        TERM_ZONE = 2'd2
    } term_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  low_edge;
        logic [FREQ_W-1:0]  high_edge;
        logic [WF_W-1:0]    width_fraction;
        logic [STEEP_W-1:0] steepness;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        term_t [N_LANES-1:0]             code;
        logic  [N_LANES-1:0][DIV_W-1:0]  num;
    } cls_word_t;

    // zone divisors (2 * half width) per lane
    typedef struct packed {
        logic [N_LANES-1:0][DIV_W-1:0] dv;
    } div_pair_t;

    // one item in the sine chain
    typedef struct packed {
        logic                           valid;
        term_t [N_LANES-1:0]            code;
        logic  [N_LANES-1:0][Q_W-1:0]   x;
    } lane_t;

endpackage

`default_nettype wire

>>> rtl/bem_queue.sv
// ============================================================================
// bem_queue
// Short word queue between the classifying front and the arithmetic back.
// ============================================================================
`default_nettype none

module bem_queue
    import bem_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cls_word_t wdata,
    input  wire logic      pop,
    output cls_word_t      rdata,
    output logic           empty,
    output logic           almost_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cls_word_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata       = mem[rd_ptr_reg];
    assign empty       = (count_reg == '0);
    // front holds up to two words in flight
    assign almost_full = (count_reg >= CNT_W'(QUEUE_DEPTH - 2));

endmodule

`default_nettype wire

>>> rtl/bem_front.sv
// ============================================================================
// bem_front
// Derives zone limits from the edges and classifies each frequency per term.
// ============================================================================
`default_nettype none

module bem_front
    import bem_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    input  wire logic [FREQ_W-1:0] freq_in,
    output logic                   push,
    output cls_word_t              word,
    output div_pair_t              divs
);

    logic [N_LANES-1:0][FREQ_W-1:0] aw_reg;
    logic [N_LANES-1:0][DIV_W-1:0]  lo_reg, hi_reg, dv_reg;
    logic [FREQ_W-1:0]              f1_reg, f2_reg;
    logic                           v1_reg, v2_reg;
    logic [N_LANES-1:0][FREQ_W-1:0] edge_val;
    logic [N_LANES-1:0][FREQ_W+WF_W-1:0] aw_prod;

    assign edge_val[LANE_HP] = cfg.low_edge;
    assign edge_val[LANE_LP] = cfg.high_edge;

    // half width = floor(edge * width / 2^16), never above edge
    always_comb
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            aw_prod[l] = (FREQ_W+WF_W)'(edge_val[l]) * (FREQ_W+WF_W)'(cfg.width_fraction);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            aw_reg[l] <= aw_prod[l][FREQ_W+15:16];
            lo_reg[l] <= {1'b0, edge_val[l]} - {1'b0, aw_reg[l]};
            hi_reg[l] <= {1'b0, edge_val[l]} + {1'b0, aw_reg[l]};
            dv_reg[l] <= {aw_reg[l], 1'b0};
        end
        f1_reg <= freq_in;
        f2_reg <= f1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // below / above / inside the zone; high-pass rises, low-pass falls
    always_comb
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            word.num[l] = {1'b0, f2_reg} - lo_reg[l];
            if ({1'b0, f2_reg} < lo_reg[l])
            begin
                word.code[l] = (l == LANE_HP) ? TERM_ZERO : TERM_ONE;
            end
            else if ({1'b0, f2_reg} >= hi_reg[l])
            begin
                word.code[l] = (l == LANE_HP) ? TERM_ONE : TERM_ZERO;
            end
            else
            begin
                word.code[l] = TERM_ZONE;
            end
        end
    end

    assign push    = v2_reg;
    assign divs.dv = dv_reg;

endmodule

`default_nettype wire

>>> rtl/bem_qsin.sv
// ============================================================================
// bem_qsin
// Pipelined sin(pi*x/2) on both lanes, odd Horner polynomial in Q30; bypass passes x through.
// ============================================================================
`default_nettype none

module bem_qsin
    import bem_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  bypass,
    input  wire lane_t in_item,
    output lane_t      out_item
);

    lane_t                          meta_reg [QS_LAT];
    logic [N_LANES-1:0][30:0]       x2_reg   [QS_LAT-2];
    logic [N_LANES-1:0][31:0]       t_reg    [QS_LAT-2];
    logic [N_LANES-1:0][Q_W-1:0]    xin_c, xfin_c;
    logic [N_LANES-1:0][33:0]       sq_p;
    logic [N_LANES-1:0][48:0]       y_p;
    logic [N_LANES-1:0][18:0]       y_c;
    lane_t                          last_c;

    function automatic logic [Q_W-1:0] cap_one(input logic [Q_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // c - ((t * x2) >> 30)
    function automatic logic [31:0] horner(input logic [31:0] c,
                                           input logic [31:0] t,
                                           input logic [30:0] x2);
        logic [62:0] p;
        p = 63'(t) * 63'(x2);
        return c - p[61:30];
    endfunction

    always_comb
    begin
        last_c = meta_reg[QS_LAT-2];
        for (int l = 0; l < N_LANES; l++)
        begin
            xin_c[l]  = cap_one(in_item.x[l]);
            sq_p[l]   = 34'(xin_c[l]) * 34'(xin_c[l]);
            xfin_c[l] = cap_one(meta_reg[QS_LAT-2].x[l]);
            y_p[l]    = 49'(t_reg[QS_LAT-3][l]) * 49'(xfin_c[l]) + 49'(32'h2000_0000);
            y_c[l]    = y_p[l][48:30];
            if (!bypass)
            begin
                last_c.x[l] = (y_c[l] > 19'(ONE_Q16)) ? ONE_Q16 : y_c[l][Q_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QS_LAT; s++)
            begin
                meta_reg[s] <= '0;
            end
        end
        else
        begin
            meta_reg[0] <= in_item;
            for (int s = 1; s < QS_LAT-1; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
            meta_reg[QS_LAT-1] <= last_c;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            x2_reg[0][l] <= sq_p[l][32:2];
            x2_reg[1][l] <= x2_reg[0][l];
            x2_reg[2][l] <= x2_reg[1][l];
            x2_reg[3][l] <= x2_reg[2][l];
            t_reg[0][l]  <= horner(SIN_C7, SIN_C9, x2_reg[0][l]);
            t_reg[1][l]  <= horner(SIN_C5, t_reg[0][l], x2_reg[1][l]);
            t_reg[2][l]  <= horner(SIN_C3, t_reg[1][l], x2_reg[2][l]);
            t_reg[3][l]  <= horner(SIN_C1, t_reg[2][l], x2_reg[3][l]);
        end
    end

    assign out_item = meta_reg[QS_LAT-1];

endmodule

`default_nettype wire

>>> rtl/bem_back.sv
// ============================================================================
// bem_back
// Zone position divider, sine iterations, squares and final product.
// ============================================================================
`default_nettype none

module bem_back
    import bem_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [STEEP_W-1:0] steepness,
    input  wire div_pair_t          divs,
    input  wire logic               q_empty,
    input  wire cls_word_t          q_word,
    output logic                    q_pop,
    output logic                    result_valid,
    output logic [Q_W-1:0]          magnitude
);

    localparam int N_QS = MAX_STEEP + 1;

    logic                           dval_reg  [POS_W+1];
    term_t [N_LANES-1:0]            dcode_reg [POS_W+1];
    logic [N_LANES-1:0][DIV_W-1:0]  rem_reg   [POS_W+1];
    logic [N_LANES-1:0][POS_W-1:0]  quo_reg   [POS_W+1];

    lane_t                          qs_link [N_QS+1];
    lane_t                          fin_in;
    logic                           sq_v_reg;
    logic [N_LANES-1:0][Q_W-1:0]    sq_reg;
    logic [N_LANES-1:0][Q_W-1:0]    term_val;
    logic [N_LANES-1:0][34:0]       sq_p;
    logic [34:0]                    m_p;
    logic                           out_v_reg;
    logic [Q_W-1:0]                 mag_reg;

    // one restoring step: remainder doubles, subtract divisor if it fits
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                                input logic [DIV_W-1:0] d);
        logic [DIV_W:0] r2;
        logic           ge;
        r2 = {r, 1'b0};
        ge = (r2 >= {1'b0, d});
        if (ge)
        begin
            r2 = r2 - {1'b0, d};
        end
        return {ge, r2[DIV_W-1:0]};
    endfunction

    assign q_pop = !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= POS_W; s++)
            begin
                dval_reg[s] <= 1'b0;
            end
        end
        else
        begin
            dval_reg[0] <= !q_empty;
            for (int s = 1; s <= POS_W; s++)
            begin
                dval_reg[s] <= dval_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dcode_reg[0] <= q_word.code;
        rem_reg[0]   <= q_word.num;
        quo_reg[0]   <= '0;
        for (int s = 1; s <= POS_W; s++)
        begin
            dcode_reg[s] <= dcode_reg[s-1];
            for (int l = 0; l < N_LANES; l++)
            begin
                {quo_reg[s][l][0], rem_reg[s][l]} <= div_step(rem_reg[s-1][l], divs.dv[l]);
                quo_reg[s][l][POS_W-1:1]          <= quo_reg[s-1][l][POS_W-2:0];
            end
        end
    end

    always_comb
    begin
        qs_link[0].valid = dval_reg[POS_W];
        qs_link[0].code  = dcode_reg[POS_W];
        for (int l = 0; l < N_LANES; l++)
        begin
            qs_link[0].x[l] = {1'b0, quo_reg[POS_W][l]};
        end
    end

    // sharpening passes, the first `steepness` of them active
    for (genvar k = 0; k < MAX_STEEP; k++)
    begin : g_iter
        logic iter_bypass;
        assign iter_bypass = ((STEEP_W+1)'(k) >= {1'b0, steepness});
        bem_qsin u_qsin (
            .clk      (clk),
            .rst_n    (rst_n),
            .bypass   (iter_bypass),
            .in_item  (qs_link[k]),
            .out_item (qs_link[k+1])
        );
    end

    // cos^2 on the falling term: sin of the mirrored position
    always_comb
    begin
        fin_in                = qs_link[MAX_STEEP];
        fin_in.x[LANE_LP]     = ONE_Q16 - qs_link[MAX_STEEP].x[LANE_LP];
    end

    bem_qsin u_qsin_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .bypass   (1'b0),
        .in_item  (fin_in),
        .out_item (qs_link[N_QS])
    );

    always_comb
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            case (qs_link[N_QS].code[l])
                TERM_ZONE: term_val[l] = qs_link[N_QS].x[l];
                TERM_ONE:  term_val[l] = ONE_Q16;
                default:   term_val[l] = '0;
            endcase
            sq_p[l] = 35'(term_val[l]) * 35'(term_val[l]) + 35'(17'h08000);
        end
        m_p = 35'(sq_reg[LANE_HP]) * 35'(sq_reg[LANE_LP]) + 35'(17'h08000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            sq_v_reg  <= qs_link[N_QS].valid;
            out_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            sq_reg[l] <= sq_p[l][32:16];
        end
        mag_reg <= m_p[32:16];
    end

    assign result_valid = out_v_reg;
    assign magnitude    = mag_reg;

endmodule

`default_nettype wire

>>> rtl/bandpass_envelope_magnitude.sv
// ============================================================================
// bandpass_envelope_magnitude
// Band-pass window gain for one frequency: high-pass term times low-pass term.
// ============================================================================
//
//  channel   signals                                  word
//  -------   --------------------------------------   ---------------------
//  query     start, busy, freq_in                     24-bit frequency
//  result    result_valid, magnitude                  17-bit Q1.16 gain
//  config    cfg_valid, cfg_ready, cfg_index,         register index + data
//            cfg_data
//
//  A query is taken at a rising edge with start high and busy low; one query
//  per cycle is sustained. The result strobes after the 2-stage front, the
//  queue, the 16-step position divider, the eight 6-stage sine units and the
//  square and product stages. The receiver cannot stall, so the back never
//  stops and pops whenever the queue holds a word; the queue never holds more
//  than one word, so busy stays low in practice.
//  Reset (rst_n low, asynchronous) loads the register reset values and
//  empties all pipelines. cfg_ready is always high.
//
// ============================================================================
`default_nettype none

module bandpass_envelope_magnitude
    import bem_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // query channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FREQ_W-1:0]     freq_in,
    // result channel
    output logic                       result_valid,
    output logic [Q_W-1:0]             magnitude,
    // configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       accept;
    logic       push;
    cls_word_t  push_word;
    cls_word_t  pop_word;
    div_pair_t  divs;
    logic       q_empty;
    logic       q_almost_full;
    logic       q_pop;

    // ---- configuration registers -------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOW_EDGE:  cfg_next.low_edge  = cfg_data[FREQ_W-1:0];
                CFG_HIGH_EDGE: cfg_next.high_edge = cfg_data[FREQ_W-1:0];
                // widths above unity saturate to 1.0
                CFG_WIDTH:     cfg_next.width_fraction =
                                   (cfg_data[WF_W-1:0] > ONE_Q16) ? ONE_Q16
                                                                  : cfg_data[WF_W-1:0];
                CFG_STEEPNESS: cfg_next.steepness = cfg_data[STEEP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_edge       <= '0;
            cfg_reg.high_edge      <= '1;
            cfg_reg.width_fraction <= WF_W'(17'h08000);
            cfg_reg.steepness      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- front: zone limits and classification -----------------------------
    assign busy   = q_almost_full;
    assign accept = start && !busy;

    bem_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (accept),
        .freq_in  (freq_in),
        .push     (push),
        .word     (push_word),
        .divs     (divs)
    );

    // ---- queue between front and back -------------------------------------
    bem_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .wdata       (push_word),
        .pop         (q_pop),
        .rdata       (pop_word),
        .empty       (q_empty),
        .almost_full (q_almost_full)
    );

    // ---- back: divide, sine passes, squares, product -----------------------
    bem_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .steepness    (cfg_reg.steepness),
        .divs         (divs),
        .q_empty      (q_empty),
        .q_word       (pop_word),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .magnitude    (magnitude)
    );

endmodule

`default_nettype wire
